// ===== rtl/core/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest point search block: request and
// response payloads, the stored point and the beat handed along the cell chain.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;

    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int DIST_W = 50;
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SCAN_W = $clog2(MAX_POINTS + 1);
    localparam int MAG_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * MAG_W;

    // squared terms whose root is above this value saturate
    localparam logic [63:0] MAG_LIMIT = 64'(1) << 25;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] point_index;
        coord_t           coord_x;
        coord_t           coord_y;
        coord_t           coord_z;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] best_distance;
        coord_t            out_x;
        coord_t            out_y;
        coord_t            out_z;
    } rsp_t;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] partial;
        point_t            point;
        point_t            target;
    } scan_beat_t;

    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_dist;
    } min_status_t;

endpackage

// ===== rtl/core/nps_cell.sv =====
// ----------------------------------------------------------------------------
// nps_cell
// One distance cell: adds the saturated squared difference of the leading
// axis to the running sum, then rotates the axes for the next cell.
// ----------------------------------------------------------------------------
module nps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  nps_pkg::scan_beat_t in_beat,
    output logic                out_valid,
    output nps_pkg::scan_beat_t out_beat
);
    import nps_pkg::*;

    logic signed [COORD_BITS:0] diff;
    logic [MAG_W-1:0]           mag_next;
    logic [SQ_W-1:0]            sq;
    logic [DIST_W-1:0]          term_next;
    logic [DIST_W:0]            sum;
    scan_beat_t                 beat3_next;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    scan_beat_t        s1_beat_reg;
    scan_beat_t        s2_beat_reg;
    scan_beat_t        s3_beat_reg;
    logic [MAG_W-1:0]  s1_mag_reg;
    logic [DIST_W-1:0] s2_term_reg;

    always_comb
    begin
        diff = $signed({in_beat.point.x[COORD_BITS-1], in_beat.point.x})
             - $signed({in_beat.target.x[COORD_BITS-1], in_beat.target.x});
        if (diff[COORD_BITS])
        begin
            mag_next = MAG_W'(-diff);
        end
        else
        begin
            mag_next = MAG_W'(diff);
        end
    end

    always_comb
    begin
        sq = SQ_W'(s1_mag_reg) * SQ_W'(s1_mag_reg);
        if ((64'(s1_mag_reg) > MAG_LIMIT) || (64'(sq) > 64'(DIST_MAX)))
        begin
            term_next = DIST_MAX;
        end
        else
        begin
            term_next = DIST_W'(sq);
        end
    end

    always_comb
    begin
        sum = {1'b0, s2_beat_reg.partial} + {1'b0, s2_term_reg};
        beat3_next = s2_beat_reg;
        if (sum[DIST_W])
        begin
            beat3_next.partial = DIST_MAX;
        end
        else
        begin
            beat3_next.partial = sum[DIST_W-1:0];
        end
        // next cell works on the following axis
        beat3_next.point.x  = s2_beat_reg.point.y;
        beat3_next.point.y  = s2_beat_reg.point.z;
        beat3_next.point.z  = s2_beat_reg.point.x;
        beat3_next.target.x = s2_beat_reg.target.y;
        beat3_next.target.y = s2_beat_reg.target.z;
        beat3_next.target.z = s2_beat_reg.target.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_beat_reg <= in_beat;
        s1_mag_reg  <= mag_next;
        s2_beat_reg <= s1_beat_reg;
        s2_term_reg <= term_next;
        s3_beat_reg <= beat3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_beat  = s3_beat_reg;

endmodule

// ===== rtl/core/nps_min.sv =====
// ----------------------------------------------------------------------------
// nps_min
// Running minimum at the end of the cell chain: keeps the best distance and
// its index over one scan, lowest index on a tie.
// ----------------------------------------------------------------------------
module nps_min (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  nps_pkg::scan_beat_t  in_beat,
    input  logic                 clear,
    output nps_pkg::min_status_t status
);
    import nps_pkg::*;

    logic              done_reg;
    logic [IDX_W-1:0]  best_index_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              take;

    // strict compare keeps the earlier index on a tie
    assign take = in_valid && (in_beat.first || (in_beat.partial < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (clear)
        begin
            done_reg <= 1'b0;
        end
        else if (in_valid && in_beat.last)
        begin
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_index_reg <= in_beat.index;
            best_dist_reg  <= in_beat.partial;
        end
    end

    assign status.done       = done_reg;
    assign status.best_index = best_index_reg;
    assign status.best_dist  = best_dist_reg;

endmodule

// ===== rtl/core/nearest_point_search_top.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search_top
// Point table with write, read and brute-force nearest query. A query streams
// the table through three distance cells, one per axis, into a running min.
// ----------------------------------------------------------------------------
// write: no response, the next request can be accepted in the following cycle
// read: registered memory read, then the response register; the next request is taken once the response is loaded
// query: one table entry per cycle from the single read port of the point
//   memory, then the 9-stage cell chain drains
// reset clears control state and point_count; the point memory is not cleared
module nearest_point_search_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  nps_pkg::req_t         req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output nps_pkg::rsp_t         rsp,
    input  logic                  cfg_write_en,
    input  logic [nps_pkg::CNT_W-1:0] cfg_write_data
);
    import nps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WAIT
    } state_t;

    localparam int NUM_CELLS = 3;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  point_count_reg, point_count_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    point_t            target_reg, target_next;
    logic              hit_reg, hit_next;
    logic              empty_reg, empty_next;
    logic              issue_valid_reg, issue_valid_next;
    logic              issue_first_reg, issue_first_next;
    logic              issue_last_reg, issue_last_next;
    logic [IDX_W-1:0]  issue_index_reg, issue_index_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    point_t            mem [MAX_POINTS];
    point_t            rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_wa;
    logic [ADDR_W-1:0] mem_ra;
    point_t            wr_point;

    logic [SCAN_W-1:0] limit;
    logic              accept;
    logic              out_free;
    logic              load;
    rsp_t              load_rsp;
    logic              min_clear;
    min_status_t       min_status;

    logic              cell_valid [NUM_CELLS+1];
    scan_beat_t        cell_beat  [NUM_CELLS+1];

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign wr_point.x = req.coord_x;
    assign wr_point.y = req.coord_y;
    assign wr_point.z = req.coord_z;

    always_comb
    begin
        if (32'(point_count_reg) > 32'(MAX_POINTS))
        begin
            limit = SCAN_W'(MAX_POINTS);
        end
        else
        begin
            limit = SCAN_W'(point_count_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        point_count_next = point_count_reg;
        scan_cnt_next    = scan_cnt_reg;
        target_next      = target_reg;
        hit_next         = hit_reg;
        empty_next       = empty_reg;
        issue_valid_next = 1'b0;
        issue_first_next = issue_first_reg;
        issue_last_next  = issue_last_reg;
        issue_index_next = issue_index_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_wa           = ADDR_W'(req.point_index);
        mem_ra           = ADDR_W'(req.point_index);
        load             = 1'b0;
        load_rsp         = '0;
        min_clear        = 1'b0;

        if (cfg_write_en)
        begin
            point_count_next = cfg_write_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_WRITE:
                        begin
                            mem_we = (32'(req.point_index) < 32'(MAX_POINTS));
                        end
                        ACT_QUERY:
                        begin
                            target_next   = wr_point;
                            scan_cnt_next = '0;
                            empty_next    = (limit == '0);
                            state_next    = (limit == '0) ? ST_WAIT : ST_SCAN;
                        end
                        ACT_READ:
                        begin
                            mem_re     = 1'b1;
                            hit_next   = (32'(req.point_index) < 32'(limit));
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                mem_re           = 1'b1;
                mem_ra           = scan_cnt_reg[ADDR_W-1:0];
                issue_valid_next = 1'b1;
                issue_first_next = (scan_cnt_reg == '0);
                issue_last_next  = (scan_cnt_reg == (limit - SCAN_W'(1)));
                issue_index_next = IDX_W'(scan_cnt_reg);
                scan_cnt_next    = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == (limit - SCAN_W'(1)))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    load_rsp.found = hit_reg;
                    if (hit_reg)
                    begin
                        load_rsp.out_x = rd_data_reg.x;
                        load_rsp.out_y = rd_data_reg.y;
                        load_rsp.out_z = rd_data_reg.z;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (out_free && (empty_reg || min_status.done))
                begin
                    load      = 1'b1;
                    min_clear = !empty_reg;
                    if (!empty_reg)
                    begin
                        load_rsp.found         = 1'b1;
                        load_rsp.nearest_index = min_status.best_index;
                        load_rsp.best_distance = min_status.best_dist;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_next       = load_rsp;
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_next       = rsp_reg;
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= '0;
            issue_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
            scan_cnt_reg    <= '0;
            empty_reg       <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            issue_valid_reg <= issue_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
            scan_cnt_reg    <= scan_cnt_next;
            empty_reg       <= empty_next;
            hit_reg         <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg      <= target_next;
        issue_first_reg <= issue_first_next;
        issue_last_reg  <= issue_last_next;
        issue_index_reg <= issue_index_next;
    end

    // point memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= wr_point;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign cell_valid[0]          = issue_valid_reg;
    assign cell_beat[0].first     = issue_first_reg;
    assign cell_beat[0].last      = issue_last_reg;
    assign cell_beat[0].index     = issue_index_reg;
    assign cell_beat[0].partial   = '0;
    assign cell_beat[0].point     = rd_data_reg;
    assign cell_beat[0].target    = target_reg;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        nps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_beat   (cell_beat[i]),
            .out_valid (cell_valid[i+1]),
            .out_beat  (cell_beat[i+1])
        );
    end

    nps_min u_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_valid[NUM_CELLS]),
        .in_beat  (cell_beat[NUM_CELLS]),
        .clear    (min_clear),
        .status   (min_status)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
